/* hw/rtl/iafg_pkg.sv */
// Package for the connection admission filter: widths, register indexes,
// decision codes and defaults. No dependencies.
package iafg_pkg;
   localparam int HistSets = 1024;
   localparam int HistWays = 4;
   localparam int CsrIdxW = 3;
   localparam int CsrDataW = 64;
   localparam int CountW = 13;
   localparam logic [CountW-1:0] CountMax = 13'h1FFF;

   localparam logic [CsrIdxW-1:0] RegMode = 3'd0;
   localparam logic [CsrIdxW-1:0] RegMaxAtt = 3'd1;
   localparam logic [CsrIdxW-1:0] RegInterval = 3'd2;
   localparam logic [CsrIdxW-1:0] RegLockout = 3'd3;
   localparam logic [CsrIdxW-1:0] RegAllowA = 3'd4;
   localparam logic [CsrIdxW-1:0] RegAllowB = 3'd5;
   localparam logic [CsrIdxW-1:0] RegDenyA = 3'd6;
   localparam logic [CsrIdxW-1:0] RegDenyB = 3'd7;

   localparam logic [1:0] DecReject = 2'd0;
   localparam logic [1:0] DecAccept = 2'd1;
   localparam logic [1:0] DecUncond = 2'd2;

   localparam logic [1:0] OrdAllowDeny = 2'd1;
   localparam logic [1:0] OrdMutual = 2'd2;

   // one history way as stored
   typedef struct packed {
      logic [31:0] addr;
      logic [31:0] tstamp;
      logic [7:0]  attempts;
      logic        flood;
   } entry_type;
endpackage

/* hw/rtl/ip_acl_flood_guard_unit.sv */
// Top level of the connection admission filter: handshake, config
// registers, rule match and a history memory walked by a sequencer.
// Depends on iafg_pkg.
//
//  channel | dir | beat contents (tdata low bits up)
//  req     | in  | tuser: req_type; tdata: client_ip, now_ms
//  rsp     | out | tdata: decision, flood_flagged, removed_count, scanned_count
//  csr     | in  | write enable, index, 64-bit data
//
// A check runs from its beat to the result in steps: set read, evaluation
// with write-back of the ways, result load; the next beat is taken after the load.
// A sweep does one set read and one write per set, over all sets.
// After reset a clearing pass over all sets runs before req is ready.
// A result waits in the rsp register; the next request is taken meanwhile
// and its result held until rsp frees.
module ip_acl_flood_guard_unit #(
   parameter int HIST_SETS = iafg_pkg::HistSets,
   parameter int HIST_WAYS = iafg_pkg::HistWays
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // client_ip[31:0], now_ms[63:32]
   input  logic        req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // decision[1:0], flood_flagged[2],
                                    // removed_count[15:3], scanned_count[28:16]
   input  logic        csr_we,
   input  logic [iafg_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [iafg_pkg::CsrDataW-1:0] csr_wdata
);
   localparam int SetW = $clog2(HIST_SETS);
   localparam int WayW = (HIST_WAYS > 1) ? $clog2(HIST_WAYS) : 1;
   localparam int EntW = $bits(iafg_pkg::entry_type);

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_CRD, ST_CEVAL, ST_SRD, ST_SEVAL, ST_HOLD
   } state_type;

   // config registers
   logic [5:0]  mode_ff;
   logic [7:0]  max_att_ff;
   logic [31:0] interval_ff, lockout_ff;
   logic [63:0] allow_a_ff, allow_b_ff, deny_a_ff, deny_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
         max_att_ff <= 8'd10;
         interval_ff <= 32'd3000;
         lockout_ff <= 32'd600000;
         allow_a_ff <= '0;
         allow_b_ff <= '0;
         deny_a_ff <= '0;
         deny_b_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            iafg_pkg::RegMode:     mode_ff <= csr_wdata[5:0];
            iafg_pkg::RegMaxAtt:   max_att_ff <= csr_wdata[7:0];
            iafg_pkg::RegInterval: interval_ff <= csr_wdata[31:0];
            iafg_pkg::RegLockout:  lockout_ff <= csr_wdata[31:0];
            iafg_pkg::RegAllowA:   allow_a_ff <= csr_wdata;
            iafg_pkg::RegAllowB:   allow_b_ff <= csr_wdata;
            iafg_pkg::RegDenyA:    deny_a_ff <= csr_wdata;
            iafg_pkg::RegDenyB:    deny_b_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // history memory: one word per set, valid bits kept in a separate array
   logic [HIST_WAYS*EntW-1:0] ent_mem [HIST_SETS];
   logic [HIST_WAYS-1:0]      vld_mem [HIST_SETS];
   logic [HIST_WAYS*EntW-1:0] ent_rd_ff;
   logic [HIST_WAYS-1:0]      vld_rd_ff;
   logic [SetW-1:0]           rd_addr, wr_addr;
   logic                      rd_en, wr_en;
   logic [HIST_WAYS*EntW-1:0] ent_wr;
   logic [HIST_WAYS-1:0]      vld_wr;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ent_mem[wr_addr] <= ent_wr;
         vld_mem[wr_addr] <= vld_wr;
      end
      if (rd_en) begin
         ent_rd_ff <= ent_mem[rd_addr];
         vld_rd_ff <= vld_mem[rd_addr];
      end
   end

   // request hold
   state_type       state_ff;
   logic [31:0]     ip_ff, now_ff;
   logic [SetW-1:0] set_ff;
   logic [SetW:0]   cnt_ff;
   logic [1:0]      dec_ff;
   logic [iafg_pkg::CountW-1:0] rem_ff, scan_ff;
   logic            rsp_vld_ff;
   logic [31:0]     rsp_data_ff;
   logic [31:0]     pend_ff;

   // rule decision
   function automatic logic hit(input logic [63:0] r, input logic [31:0] ip);
      hit = ((ip & r[31:0]) == (r[63:32] & r[31:0]));
   endfunction

   logic al, dn;
   logic [1:0] rule_dec;
   always_comb begin
      al = (mode_ff[2] && hit(allow_a_ff, ip_ff)) || (mode_ff[3] && hit(allow_b_ff, ip_ff));
      dn = (mode_ff[4] && hit(deny_a_ff, ip_ff)) || (mode_ff[5] && hit(deny_b_ff, ip_ff));
      case (mode_ff[1:0])
         iafg_pkg::OrdAllowDeny:
            rule_dec = al ? iafg_pkg::DecUncond : (dn ? iafg_pkg::DecReject : iafg_pkg::DecAccept);
         iafg_pkg::OrdMutual:
            rule_dec = (al && !dn) ? iafg_pkg::DecUncond : iafg_pkg::DecReject;
         default:
            rule_dec = dn ? iafg_pkg::DecReject : (al ? iafg_pkg::DecUncond : iafg_pkg::DecAccept);
      endcase
   end

   // per-set evaluation
   iafg_pkg::entry_type ways [HIST_WAYS];
   logic [31:0] ages [HIST_WAYS];
   always_comb begin
      for (int w = 0; w < HIST_WAYS; w++) begin
         ways[w] = ent_rd_ff[w*EntW +: EntW];
         ages[w] = now_ff - ways[w].tstamp;
      end
   end

   logic [HIST_WAYS*EntW-1:0] c_ent;
   logic [HIST_WAYS-1:0]      c_vld;
   logic [1:0]                c_dec;
   logic                      c_flag;
   always_comb begin
      logic found, have_v;
      logic [31:0] best;
      iafg_pkg::entry_type e;
      logic [WayW-1:0] vic;
      found = 1'b0;
      have_v = 1'b0;
      best = '0;
      vic = '0;
      e = '0;
      c_ent = ent_rd_ff;
      c_vld = vld_rd_ff;
      c_dec = dec_ff;
      c_flag = 1'b0;
      for (int w = 0; w < HIST_WAYS; w++) begin
         if (!found && vld_rd_ff[w] && ways[w].addr == ip_ff) begin
            found = 1'b1;
            e = ways[w];
            if (e.flood) begin
               c_dec = (dec_ff == iafg_pkg::DecUncond) ? iafg_pkg::DecAccept
                                                       : iafg_pkg::DecReject;
               c_flag = 1'b1;
            end else if (ages[w] < interval_ff) begin
               e.tstamp = now_ff;
               if (e.attempts != 8'hFF) e.attempts = e.attempts + 8'd1;
               if (ways[w].attempts >= max_att_ff) begin
                  e.flood = 1'b1;
                  c_dec = (dec_ff == iafg_pkg::DecUncond) ? iafg_pkg::DecAccept
                                                          : iafg_pkg::DecReject;
                  c_flag = 1'b1;
               end
            end else begin
               e.tstamp = now_ff;
               e.attempts = '0;
            end
            c_ent[w*EntW +: EntW] = e;
         end
      end
      if (!found) begin
         for (int w = HIST_WAYS-1; w >= 0; w--)
            if (!vld_rd_ff[w]) begin
               have_v = 1'b1;
               vic = WayW'(w);
            end
         if (!have_v)
            for (int w = 0; w < HIST_WAYS; w++)
               if (!ways[w].flood && (!have_v || ages[w] > best)) begin
                  have_v = 1'b1;
                  vic = WayW'(w);
                  best = ages[w];
               end
         if (have_v) begin
            e.addr = ip_ff;
            e.tstamp = now_ff;
            e.attempts = '0;
            e.flood = 1'b0;
            c_ent[vic*EntW +: EntW] = e;
            c_vld[vic] = 1'b1;
         end
      end
   end

   // sweep of one set
   logic [HIST_WAYS-1:0] s_vld;
   logic [iafg_pkg::CountW-1:0] s_rem, s_scan;
   always_comb begin
      logic [33:0] lim;
      lim = {2'b0, interval_ff} + {1'b0, interval_ff, 1'b0};
      s_vld = vld_rd_ff;
      s_rem = rem_ff;
      s_scan = scan_ff;
      for (int w = 0; w < HIST_WAYS; w++)
         if (vld_rd_ff[w]) begin
            if (s_scan != iafg_pkg::CountMax) s_scan = s_scan + 1'b1;
            if ((!ways[w].flood && {2'b0, ages[w]} > lim) ||
                (ways[w].flood && ages[w] > lockout_ff)) begin
               s_vld[w] = 1'b0;
               if (s_rem != iafg_pkg::CountMax) s_rem = s_rem + 1'b1;
            end
         end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata = rsp_data_ff;

   always_comb begin
      rd_en = 1'b0;
      rd_addr = set_ff;
      wr_en = 1'b0;
      wr_addr = set_ff;
      ent_wr = c_ent;
      vld_wr = c_vld;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            vld_wr = '0;
         end
         ST_CRD, ST_SRD: rd_en = 1'b1;
         ST_CEVAL: wr_en = 1'b1;
         ST_SEVAL: begin
            wr_en = 1'b1;
            ent_wr = ent_rd_ff;
            vld_wr = s_vld;
         end
         default: ;
      endcase
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         set_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         // result register: load from hold, drop on an accepted beat
         if (state_ff == ST_HOLD && (!rsp_vld_ff || rsp_tready)) rsp_vld_ff <= 1'b1;
         else if (rsp_vld_ff && rsp_tready) rsp_vld_ff <= 1'b0;
         case (state_ff)
            ST_CLEAR: begin
               set_ff <= set_ff + 1'b1;
               if (set_ff == SetW'(HIST_SETS-1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: if (req_tvalid) begin
               ip_ff <= req_tdata[31:0];
               now_ff <= req_tdata[63:32];
               rem_ff <= '0;
               scan_ff <= '0;
               cnt_ff <= '0;
               if (req_tuser) begin
                  set_ff <= '0;
                  state_ff <= ST_SRD;
               end else begin
                  set_ff <= SetW'(req_tdata[31:0] % HIST_SETS);
                  state_ff <= ST_CRD;
               end
            end
            ST_CRD: begin
               dec_ff <= rule_dec;
               state_ff <= ST_CEVAL;
            end
            ST_CEVAL: begin
               pend_ff <= {3'b0, 26'b0, c_flag, c_dec};
               state_ff <= ST_HOLD;
            end
            ST_SRD: state_ff <= ST_SEVAL;
            ST_SEVAL: begin
               rem_ff <= s_rem;
               scan_ff <= s_scan;
               set_ff <= set_ff + 1'b1;
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == (SetW+1)'(HIST_SETS-1)) begin
                  pend_ff <= {3'b0, s_scan, s_rem, 1'b0, iafg_pkg::DecReject};
                  state_ff <= ST_HOLD;
               end else state_ff <= ST_SRD;
            end
            ST_HOLD: if (!rsp_vld_ff || rsp_tready) begin
               rsp_data_ff <= pend_ff;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule

/* tb/tb.sv */
// Self-checking bench for ip_acl_flood_guard_unit: directed table, then random
// phases checked against an in-bench model of rules and flood history.
// Depends on iafg_pkg and the unit's RTL.
`timescale 1ns / 100ps

module tb;
   localparam int NumEntries = iafg_pkg::HistSets * iafg_pkg::HistWays;
   localparam int SetBits = $clog2(iafg_pkg::HistSets);
   localparam int StallLimit = 20000;

   typedef enum logic [1:0] {OpCheck, OpSweep, OpCsr} op_kind_type;

   typedef struct packed {
      logic [1:0]                  decision;
      logic                        flagged;
      logic [iafg_pkg::CountW-1:0] removed;
      logic [iafg_pkg::CountW-1:0] scanned;
   } verdict_type;

   typedef struct {
      op_kind_type kind;
      logic [63:0] a;        // client_ip or register index
      logic [63:0] b;        // now_ms or register data
      bit          typed;
      verdict_type want;
   } row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [iafg_pkg::CsrIdxW-1:0]  csr_index = '0;
   logic [iafg_pkg::CsrDataW-1:0] csr_wdata = '0;

   // shadow configuration
   logic [5:0]  acl_mode;
   logic [7:0]  flood_limit;
   logic [31:0] window_ms;
   logic [31:0] lock_ms;
   logic [63:0] allow_a, allow_b, deny_a, deny_b;

   // shadow history
   bit          hv_valid [NumEntries];
   logic [31:0] hv_addr  [NumEntries];
   logic [31:0] hv_time  [NumEntries];
   logic [7:0]  hv_count [NumEntries];
   bit          hv_flood [NumEntries];

   verdict_type pending_q[$];
   int          err_cnt = 0;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   logic        hold_start = 1'b0;
   int          hold_left = 0;
   int          quiet_cycles = 0;

   ip_acl_flood_guard_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------- model ----------------
   function automatic bit rule_match(logic [63:0] rule, logic [31:0] ip);
      return (ip & rule[31:0]) == (rule[63:32] & rule[31:0]);
   endfunction

   function automatic logic [1:0] acl_verdict(logic [31:0] ip);
      bit al, dn;
      al = (acl_mode[2] && rule_match(allow_a, ip)) || (acl_mode[3] && rule_match(allow_b, ip));
      dn = (acl_mode[4] && rule_match(deny_a, ip)) || (acl_mode[5] && rule_match(deny_b, ip));
      case (acl_mode[1:0])
         iafg_pkg::OrdAllowDeny:
            return al ? iafg_pkg::DecUncond : (dn ? iafg_pkg::DecReject : iafg_pkg::DecAccept);
         iafg_pkg::OrdMutual:
            return (al && !dn) ? iafg_pkg::DecUncond : iafg_pkg::DecReject;
         default:
            return dn ? iafg_pkg::DecReject : (al ? iafg_pkg::DecUncond : iafg_pkg::DecAccept);
      endcase
   endfunction

   task automatic shadow_reset();
      acl_mode = '0; flood_limit = 8'd10; window_ms = 32'd3000; lock_ms = 32'd600000;
      allow_a = '0; allow_b = '0; deny_a = '0; deny_b = '0;
      foreach (hv_valid[e]) hv_valid[e] = 0;
   endtask

   task automatic shadow_csr(logic [iafg_pkg::CsrIdxW-1:0] idx, logic [63:0] data);
      case (idx)
         iafg_pkg::RegMode:     acl_mode = data[5:0];
         iafg_pkg::RegMaxAtt:   flood_limit = data[7:0];
         iafg_pkg::RegInterval: window_ms = data[31:0];
         iafg_pkg::RegLockout:  lock_ms = data[31:0];
         iafg_pkg::RegAllowA:   allow_a = data;
         iafg_pkg::RegAllowB:   allow_b = data;
         iafg_pkg::RegDenyA:    deny_a = data;
         iafg_pkg::RegDenyB:    deny_b = data;
         default: ;
      endcase
   endtask

   task automatic history_check(logic [31:0] ip, logic [31:0] now, output verdict_type r);
      logic [1:0]  ok;
      int          base, e, victim;
      logic [31:0] best, age;
      logic [7:0]  c;
      ok = acl_verdict(ip);
      base = int'(ip % iafg_pkg::HistSets) * iafg_pkg::HistWays;
      victim = -1;
      best = '0;
      r = '0;
      r.decision = ok;
      for (int w = 0; w < iafg_pkg::HistWays; w++) begin
         e = base + w;
         if (hv_valid[e] && hv_addr[e] == ip) begin
            if (hv_flood[e]) begin
               r.decision = (ok == iafg_pkg::DecUncond) ? iafg_pkg::DecAccept
                                                        : iafg_pkg::DecReject;
               r.flagged = 1'b1;
               return;
            end
            if (now - hv_time[e] < window_ms) begin
               c = hv_count[e];
               hv_time[e] = now;
               if (c != 8'hFF) hv_count[e] = c + 8'd1;
               // limit compared against the count before the bump
               if (c >= flood_limit) begin
                  hv_flood[e] = 1;
                  r.decision = (ok == iafg_pkg::DecUncond) ? iafg_pkg::DecAccept
                                                           : iafg_pkg::DecReject;
                  r.flagged = 1'b1;
               end
               return;
            end
            hv_time[e] = now;
            hv_count[e] = '0;
            return;
         end
      end
      // allocate: lowest free way, else oldest unflagged way
      for (int w = 0; w < iafg_pkg::HistWays; w++)
         if (victim < 0 && !hv_valid[base + w]) victim = w;
      if (victim < 0)
         for (int w = 0; w < iafg_pkg::HistWays; w++) begin
            age = now - hv_time[base + w];
            if (!hv_flood[base + w] && (victim < 0 || age > best)) begin
               victim = w;
               best = age;
            end
         end
      if (victim >= 0) begin
         e = base + victim;
         hv_valid[e] = 1; hv_addr[e] = ip; hv_time[e] = now;
         hv_count[e] = '0; hv_flood[e] = 0;
      end
   endtask

   task automatic history_sweep(logic [31:0] now, output verdict_type r);
      logic [33:0] idle_lim;
      logic [31:0] age;
      idle_lim = {2'b0, window_ms} * 34'd3;
      r = '0;
      for (int e = 0; e < NumEntries; e++) begin
         if (!hv_valid[e]) continue;
         if (r.scanned != iafg_pkg::CountMax) r.scanned++;
         age = now - hv_time[e];
         if ((!hv_flood[e] && {2'b0, age} > idle_lim) || (hv_flood[e] && age > lock_ms)) begin
            hv_valid[e] = 0;
            if (r.removed != iafg_pkg::CountMax) r.removed++;
         end
      end
   endtask

   // ---------------- result side ----------------
   task automatic report_err(string what, int got, int want);
      $display("%0t: MISMATCH %s got %0d want %0d", $realtime, what, got, want);
      err_cnt++;
   endtask

   always @(posedge clock) begin
      verdict_type w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_q.size() == 0) begin
            report_err("unexpected result beat", 1, 0);
         end else begin
            w = pending_q.pop_front();
            if (rsp_tdata[1:0] != w.decision)
               report_err("decision", int'(rsp_tdata[1:0]), int'(w.decision));
            if (rsp_tdata[2] != w.flagged)
               report_err("flood_flagged", int'(rsp_tdata[2]), int'(w.flagged));
            if (rsp_tdata[15:3] != w.removed)
               report_err("removed_count", int'(rsp_tdata[15:3]), int'(w.removed));
            if (rsp_tdata[28:16] != w.scanned)
               report_err("scanned_count", int'(rsp_tdata[28:16]), int'(w.scanned));
         end
      end
      if (hold_left > 0) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // long receiver hold-off counter
   always @(posedge clock) begin
      if (hold_start) hold_left <= 400;
      else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // watchdog: cycles without any accepted beat or register write
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > StallLimit) begin
         $display("ip_acl_flood_guard_unit regression: fail");
         $finish;
      end
   end

   // ---------------- request side ----------------
   task automatic send_beat(bit sweep, logic [31:0] ip, logic [31:0] now, bit typed,
                            verdict_type want);
      verdict_type r;
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= sweep;
      req_tdata <= {now, ip};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (sweep) history_sweep(now, r);
      else history_check(ip, now, r);
      if (typed && r != want) report_err("typed expectation vs model", int'(r), int'(want));
      pending_q = {pending_q, (typed ? want : r)};
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      wait (pending_q.size() == 0);
      repeat (6) @(posedge clock);
   endtask

   task automatic csr_write(logic [iafg_pkg::CsrIdxW-1:0] idx, logic [63:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      shadow_csr(idx, data);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   function automatic verdict_type vd(logic [1:0] d, logic f, int rem, int scn);
      verdict_type v;
      v.decision = d;
      v.flagged = f;
      v.removed = iafg_pkg::CountW'(rem);
      v.scanned = iafg_pkg::CountW'(scn);
      return v;
   endfunction

   row_type     rows[$];
   logic [31:0] pool[24];
   logic [31:0] cur_now;

   function automatic logic [63:0] pick_rule();
      case ($urandom_range(0, 3))
         0: return {pool[$urandom_range(0, 23)], 32'hFFFFFFFF};
         1: return {pool[$urandom_range(0, 23)], 32'hFFFFF000};
         2: return {$urandom, 32'h0};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   initial begin
      row_type rw;
      logic [SetBits-1:0] set_id;
      int n;
      shadow_reset();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      rows = '{
         '{OpCheck, 64'h0, 64'h0, 1'b1, vd(iafg_pkg::DecAccept, 1'b0, 0, 0)},
         '{OpCheck, 64'hFFFFFFFF, 64'hFFFFFFFF, 1'b1, vd(iafg_pkg::DecAccept, 1'b0, 0, 0)},
         '{OpSweep, 64'hFFFFFFFF, 64'h0, 1'b1, vd(iafg_pkg::DecReject, 1'b0, 0, 2)},
         '{OpCsr, 64'(iafg_pkg::RegMaxAtt), 64'd0, 1'b0, '0},
         '{OpCheck, 64'h0, 64'd5, 1'b1, vd(iafg_pkg::DecReject, 1'b1, 0, 0)},
         '{OpCsr, 64'(iafg_pkg::RegAllowA), 64'h0A000000_FF000000, 1'b0, '0},
         '{OpCsr, 64'(iafg_pkg::RegDenyA), 64'h0A000100_FFFFFF00, 1'b0, '0},
         '{OpCsr, 64'(iafg_pkg::RegMode), 64'h14, 1'b0, '0},
         '{OpCheck, 64'h0A000105, 64'd10, 1'b1, vd(iafg_pkg::DecReject, 1'b0, 0, 0)},
         '{OpCheck, 64'h0A000205, 64'd11, 1'b1, vd(iafg_pkg::DecUncond, 1'b0, 0, 0)},
         '{OpCsr, 64'(iafg_pkg::RegMode), 64'h15, 1'b0, '0},
         '{OpCheck, 64'h0A000105, 64'd12, 1'b0, '0},
         '{OpCsr, 64'(iafg_pkg::RegMode), 64'h16, 1'b0, '0},
         '{OpCheck, 64'h0A000106, 64'd13, 1'b0, '0},
         '{OpCheck, 64'h0A000205, 64'd14, 1'b0, '0},
         '{OpCsr, 64'(iafg_pkg::RegAllowB), 64'h00000000_FFFFFFFF, 1'b0, '0},
         '{OpCsr, 64'(iafg_pkg::RegDenyB), 64'hFFFFFFFF_FFFFFFFF, 1'b0, '0},
         '{OpCsr, 64'(iafg_pkg::RegMode), 64'h3F, 1'b0, '0},
         '{OpCheck, 64'h0, 64'd20, 1'b0, '0},
         '{OpCheck, 64'h00000100, 64'd21, 1'b0, '0},
         '{OpCheck, 64'h00000500, 64'd22, 1'b0, '0},
         '{OpCheck, 64'h00000900, 64'd23, 1'b0, '0},
         '{OpCheck, 64'h00000D00, 64'd24, 1'b0, '0},
         '{OpCheck, 64'h00001100, 64'd30, 1'b0, '0},
         '{OpCsr, 64'(iafg_pkg::RegInterval), 64'd0, 1'b0, '0},
         '{OpCsr, 64'(iafg_pkg::RegLockout), 64'd0, 1'b0, '0},
         '{OpSweep, 64'h0, 64'd100, 1'b0, '0}
      };
      foreach (rows[i]) begin
         rw = rows[i];
         if (rw.kind == OpCsr) begin
            drain();
            csr_write(rw.a[iafg_pkg::CsrIdxW-1:0], rw.b);
         end else begin
            send_beat(rw.kind == OpSweep, rw.a[31:0], rw.b[31:0], rw.typed, rw.want);
         end
      end

      // random phases over the idle profiles
      for (int ph = 0; ph < 8; ph++) begin
         drain();
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
         endcase
         for (int s = 0; s < 4; s++) begin
            set_id = SetBits'($urandom_range(0, iafg_pkg::HistSets - 1));
            for (int k = 0; k < 6; k++)
               pool[s * 6 + k] = {(32 - SetBits)'($urandom_range(0, 32'h3FFFFF)), set_id};
         end
         cur_now = (ph == 3) ? 32'hFFFFFF00 : $urandom;
         csr_write(iafg_pkg::RegMode,
                   (ph == 0) ? 64'd0 : (ph == 7) ? 64'd63 : 64'($urandom_range(0, 63)));
         csr_write(iafg_pkg::RegMaxAtt,
                   (ph == 5) ? 64'd254 : (ph == 6) ? 64'd0 : 64'($urandom_range(0, 4)));
         csr_write(iafg_pkg::RegInterval, (ph == 4) ? 64'hFFFFFFFF : (ph == 6) ? 64'd0 :
                   64'($urandom_range(30, 300)));
         csr_write(iafg_pkg::RegLockout, (ph == 5) ? 64'hFFFFFFFF : (ph == 2) ? 64'd0 :
                   64'($urandom_range(200, 5000)));
         csr_write(iafg_pkg::RegAllowA, pick_rule());
         csr_write(iafg_pkg::RegAllowB, pick_rule());
         csr_write(iafg_pkg::RegDenyA, pick_rule());
         csr_write(iafg_pkg::RegDenyB, pick_rule());
         n = 0;
         while (n < 60) begin
            if (ph == 1 && n == 10) hold_start <= 1'b1;
            if (ph == 1 && n == 11) hold_start <= 1'b0;
            if (ph == 3 && n == 30) begin
               req_tvalid <= 1'b0;
               wait (pending_q.size() == 0);
               @(posedge clock);
            end
            case ($urandom_range(0, 99))
               0, 1, 2: send_beat(1'b1, $urandom, cur_now, 1'b0, '0);
               3, 4, 5, 6, 7, 8:
                  send_beat(1'b0, $urandom, $urandom, 1'b0, '0);
               default: begin
                  if ($urandom_range(0, 19) == 0) cur_now += $urandom_range(1000, 200000);
                  else cur_now += $urandom_range(0, 40);
                  send_beat(1'b0, pool[$urandom_range(0, 23)], cur_now, 1'b0, '0);
               end
            endcase
            n++;
         end
      end

      drain();
      repeat (20) @(posedge clock);
      if (err_cnt == 0) begin
         $display("ip_acl_flood_guard_unit regression: pass");
      end else begin
         $display("ip_acl_flood_guard_unit regression: fail");
      end
      $finish;
   end
endmodule
